// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay, disabled during reset.
`define ASSERT_DELAYED(lbl, clk, rstn, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbp_pkg.sv =====
// Package: types, constants and the divider step for pixel back-projection.
`timescale 1ns / 1ps
`default_nettype none
package pbp_pkg;

    localparam int PIX_W      = 16;
    localparam int FOC_W      = 20;
    localparam int DEP_W      = 24;
    localparam int SIZE_W     = 12;
    localparam int CAM_W      = 32;
    localparam int ST_W       = 2;
    localparam int MAG_W      = PIX_W + DEP_W;
    localparam int NUM_CELLS  = MAG_W;
    localparam int LATENCY    = NUM_CELLS + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;

    localparam logic [FOC_W-1:0]  RST_FOCAL_X       = 20'd16000;
    localparam logic [FOC_W-1:0]  RST_FOCAL_Y       = 20'd16000;
    localparam logic [PIX_W-1:0]  RST_CENTER_X      = 16'd5120;
    localparam logic [PIX_W-1:0]  RST_CENTER_Y      = 16'd3840;
    localparam logic [DEP_W-1:0]  RST_DEFAULT_DEPTH = 24'd65536;
    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE    = 12'd0;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_CFG   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_DEPTH = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT       = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             depth_present;
        logic [DEP_W-1:0] target_depth;
    } t_target;

    typedef struct packed {
        logic signed [CAM_W-1:0] cam_x;
        logic signed [CAM_W-1:0] cam_y;
        logic        [DEP_W-1:0] cam_z;
        logic        [ST_W-1:0]  status;
    } t_result;

    typedef struct packed {
        logic [FOC_W-1:0]  focal_x;
        logic [FOC_W-1:0]  focal_y;
        logic [PIX_W-1:0]  center_x;
        logic [PIX_W-1:0]  center_y;
        logic [DEP_W-1:0]  default_depth;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } t_cfg;

    // One axis in flight through the divider: dividend shifts out of dq
    // from the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic             neg;
        logic [FOC_W-1:0] den;
        logic [FOC_W-1:0] rem;
        logic [MAG_W-1:0] dq;
    } t_lane;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [DEP_W-1:0] z;
    } t_meta;

    // One restoring-division step.
    function automatic t_lane div_step(input t_lane a);
        logic [FOC_W:0] shifted;
        logic [FOC_W:0] diff;
        t_lane          b;
        shifted = {a.rem, a.dq[MAG_W-1]};
        diff    = shifted - {1'b0, a.den};
        b       = a;
        if (shifted >= {1'b0, a.den}) begin
            b.rem = diff[FOC_W-1:0];
            b.dq  = {a.dq[MAG_W-2:0], 1'b1};
        end else begin
            b.rem = shifted[FOC_W-1:0];
            b.dq  = {a.dq[MAG_W-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pbp_front.sv =====
// Front end: depth select, config checks, offset from center, numerator product.
`timescale 1ns / 1ps
`default_nettype none
module pbp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire pbp_pkg::t_target i_target,
    input  wire pbp_pkg::t_cfg   i_cfg,
    output logic                 o_valid,
    output pbp_pkg::t_lane       o_x,
    output pbp_pkg::t_lane       o_y,
    output pbp_pkg::t_meta       o_meta
);

    logic                        n_cfg_ok;
    logic [pbp_pkg::DEP_W-1:0]   n_z;
    logic [pbp_pkg::ST_W-1:0]    n_status;
    logic [pbp_pkg::PIX_W:0]     n_dx;
    logic [pbp_pkg::PIX_W:0]     n_dy;
    logic [pbp_pkg::PIX_W:0]     n_ndx;
    logic [pbp_pkg::PIX_W:0]     n_ndy;

    logic                        r_a_valid;
    logic                        r_a_neg_x;
    logic                        r_a_neg_y;
    logic [pbp_pkg::PIX_W-1:0]   r_a_mag_x;
    logic [pbp_pkg::PIX_W-1:0]   r_a_mag_y;
    logic [pbp_pkg::FOC_W-1:0]   r_a_den_x;
    logic [pbp_pkg::FOC_W-1:0]   r_a_den_y;
    pbp_pkg::t_meta              r_a_meta;

    logic                        r_b_valid;
    pbp_pkg::t_lane              r_b_x;
    pbp_pkg::t_lane              r_b_y;
    pbp_pkg::t_meta              r_b_meta;

    always_comb begin
        n_cfg_ok = (i_cfg.focal_x != '0) && (i_cfg.focal_y != '0)
                && (i_cfg.default_depth != '0)
                && ((i_cfg.image_width == '0) == (i_cfg.image_height == '0));
        n_z = i_target.depth_present ? i_target.target_depth : i_cfg.default_depth;
        if (!n_cfg_ok) begin
            n_status = pbp_pkg::ST_BAD_CFG;
        end else if (n_z == '0) begin
            n_status = pbp_pkg::ST_BAD_DEPTH;
        end else begin
            n_status = pbp_pkg::ST_OK;
        end
        n_dx  = {1'b0, i_target.pixel_x} - {1'b0, i_cfg.center_x};
        n_dy  = {1'b0, i_target.pixel_y} - {1'b0, i_cfg.center_y};
        n_ndx = {1'b0, i_cfg.center_x} - {1'b0, i_target.pixel_x};
        n_ndy = {1'b0, i_cfg.center_y} - {1'b0, i_target.pixel_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg_x       <= n_dx[pbp_pkg::PIX_W];
        r_a_neg_y       <= n_dy[pbp_pkg::PIX_W];
        r_a_mag_x       <= n_dx[pbp_pkg::PIX_W] ? n_ndx[pbp_pkg::PIX_W-1:0]
                                                : n_dx[pbp_pkg::PIX_W-1:0];
        r_a_mag_y       <= n_dy[pbp_pkg::PIX_W] ? n_ndy[pbp_pkg::PIX_W-1:0]
                                                : n_dy[pbp_pkg::PIX_W-1:0];
        r_a_den_x       <= i_cfg.focal_x;
        r_a_den_y       <= i_cfg.focal_y;
        r_a_meta.status <= n_status;
        r_a_meta.z      <= n_z;

        r_b_x.neg <= r_a_neg_x;
        r_b_x.den <= r_a_den_x;
        r_b_x.rem <= '0;
        r_b_x.dq  <= r_a_mag_x * r_a_meta.z;
        r_b_y.neg <= r_a_neg_y;
        r_b_y.den <= r_a_den_y;
        r_b_y.rem <= '0;
        r_b_y.dq  <= r_a_mag_y * r_a_meta.z;
        r_b_meta  <= r_a_meta;
    end

    assign o_valid = r_b_valid;
    assign o_x     = r_b_x;
    assign o_y     = r_b_y;
    assign o_meta  = r_b_meta;

endmodule
`default_nettype wire

// ===== rtl/pbp_cell.sv =====
// Divider cell: one quotient bit for each axis, passes the beat to the next cell.
`timescale 1ns / 1ps
`default_nettype none
module pbp_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pbp_pkg::t_lane i_x,
    input  wire pbp_pkg::t_lane i_y,
    input  wire pbp_pkg::t_meta i_meta,
    output logic                o_valid,
    output pbp_pkg::t_lane      o_x,
    output pbp_pkg::t_lane      o_y,
    output pbp_pkg::t_meta      o_meta
);

    logic           r_valid;
    pbp_pkg::t_lane r_x;
    pbp_pkg::t_lane r_y;
    pbp_pkg::t_meta r_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= pbp_pkg::div_step(i_x);
        r_y    <= pbp_pkg::div_step(i_y);
        r_meta <= i_meta;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_meta  = r_meta;

endmodule
`default_nettype wire

// ===== rtl/pbp_back.sv =====
// Back end: sign restore, clamp to 32 bits, status merge, result register.
`timescale 1ns / 1ps
`default_nettype none
module pbp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pbp_pkg::t_lane i_x,
    input  wire pbp_pkg::t_lane i_y,
    input  wire pbp_pkg::t_meta i_meta,
    output logic                o_valid,
    output pbp_pkg::t_result    o_result
);

    // Returns {saturated, value}.
    function automatic logic [pbp_pkg::CAM_W:0] clamp(
        input logic                      neg,
        input logic [pbp_pkg::MAG_W-1:0] q
    );
        logic                      s;
        logic [pbp_pkg::CAM_W-1:0] v;
        logic [pbp_pkg::CAM_W-1:0] lo;
        lo = q[pbp_pkg::CAM_W-1:0];
        if (neg) begin
            s = (q[pbp_pkg::MAG_W-1:pbp_pkg::CAM_W] != '0)
             || (lo[pbp_pkg::CAM_W-1] && (lo[pbp_pkg::CAM_W-2:0] != '0));
            v = s ? {1'b1, {(pbp_pkg::CAM_W-1){1'b0}}}
                  : (~lo + {{(pbp_pkg::CAM_W-1){1'b0}}, 1'b1});
        end else begin
            s = (q[pbp_pkg::MAG_W-1:pbp_pkg::CAM_W-1] != '0);
            v = s ? {1'b0, {(pbp_pkg::CAM_W-1){1'b1}}} : lo;
        end
        return {s, v};
    endfunction

    logic [pbp_pkg::CAM_W:0] n_cx;
    logic [pbp_pkg::CAM_W:0] n_cy;
    pbp_pkg::t_result        n_result;

    logic                    r_valid;
    pbp_pkg::t_result        r_result;

    always_comb begin
        n_cx = clamp(i_x.neg, i_x.dq);
        n_cy = clamp(i_y.neg, i_y.dq);
        if (i_meta.status != pbp_pkg::ST_OK) begin
            n_result.cam_x  = '0;
            n_result.cam_y  = '0;
            n_result.cam_z  = '0;
            n_result.status = i_meta.status;
        end else begin
            n_result.cam_x  = n_cx[pbp_pkg::CAM_W-1:0];
            n_result.cam_y  = n_cy[pbp_pkg::CAM_W-1:0];
            n_result.cam_z  = i_meta.z;
            n_result.status = (n_cx[pbp_pkg::CAM_W] || n_cy[pbp_pkg::CAM_W])
                            ? pbp_pkg::ST_SAT : pbp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/pixel_back_projection_top.sv =====
// Top level: config registers and the front, cell chain and back of the projector.
//
// Back-projects one pixel target per beat to camera X/Y/Z. A target is taken on
// any clock with start high and busy low; busy is high only while reset is held,
// so a new target can enter every cycle. Each result appears on o_result for
// exactly one cycle with o_valid high, in the order taken; the receiver cannot
// stall it. A target passes through two front stages, the 40-cell divider
// chain (one quotient bit per cell, both axes side by side) and one output
// stage on its way to the result. Config writes take effect at once and must
// only be issued while no target is in flight.
`timescale 1ns / 1ps
`default_nettype none
module pixel_back_projection_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire pbp_pkg::t_target                  i_target,
    output logic                                   o_valid,
    output pbp_pkg::t_result                       o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [pbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pbp_pkg::t_cfg  r_cfg;
    logic           w_accept;

    logic           w_valid [0:pbp_pkg::NUM_CELLS];
    pbp_pkg::t_lane w_x     [0:pbp_pkg::NUM_CELLS];
    pbp_pkg::t_lane w_y     [0:pbp_pkg::NUM_CELLS];
    pbp_pkg::t_meta w_meta  [0:pbp_pkg::NUM_CELLS];

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x       <= pbp_pkg::RST_FOCAL_X;
            r_cfg.focal_y       <= pbp_pkg::RST_FOCAL_Y;
            r_cfg.center_x      <= pbp_pkg::RST_CENTER_X;
            r_cfg.center_y      <= pbp_pkg::RST_CENTER_Y;
            r_cfg.default_depth <= pbp_pkg::RST_DEFAULT_DEPTH;
            r_cfg.image_width   <= pbp_pkg::RST_IMAGE_SIZE;
            r_cfg.image_height  <= pbp_pkg::RST_IMAGE_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbp_pkg::REG_FOCAL_X: begin
                    r_cfg.focal_x <= i_cfg_data[pbp_pkg::FOC_W-1:0];
                end
                pbp_pkg::REG_FOCAL_Y: begin
                    r_cfg.focal_y <= i_cfg_data[pbp_pkg::FOC_W-1:0];
                end
                pbp_pkg::REG_CENTER_X: begin
                    r_cfg.center_x <= i_cfg_data[pbp_pkg::PIX_W-1:0];
                end
                pbp_pkg::REG_CENTER_Y: begin
                    r_cfg.center_y <= i_cfg_data[pbp_pkg::PIX_W-1:0];
                end
                pbp_pkg::REG_DEFAULT_DEPTH: begin
                    r_cfg.default_depth <= i_cfg_data[pbp_pkg::DEP_W-1:0];
                end
                pbp_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[pbp_pkg::SIZE_W-1:0];
                end
                pbp_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[pbp_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_target (i_target),
        .i_cfg    (r_cfg),
        .o_valid  (w_valid[0]),
        .o_x      (w_x[0]),
        .o_y      (w_y[0]),
        .o_meta   (w_meta[0])
    );

    for (genvar g = 0; g < pbp_pkg::NUM_CELLS; g++) begin : g_cell
        pbp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_meta  (w_meta[g]),
            .o_valid (w_valid[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_meta  (w_meta[g+1])
        );
    end

    pbp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[pbp_pkg::NUM_CELLS]),
        .i_x      (w_x[pbp_pkg::NUM_CELLS]),
        .i_y      (w_y[pbp_pkg::NUM_CELLS]),
        .i_meta   (w_meta[pbp_pkg::NUM_CELLS]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/pbp_checker.sv =====
// Port-level checker for the back-projection top, bound to it below.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pbp_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire pbp_pkg::t_result o_result
);

    `ASSERT_DELAYED(a_latency, i_clk, i_rst_n, start && !busy, pbp_pkg::LATENCY, o_valid, "accepted beat gave no result")
    `ASSERT_DELAYED(a_no_spurious, i_clk, i_rst_n, !(start && !busy), pbp_pkg::LATENCY, !o_valid, "result without a beat")
    `ASSERT_IMPLIES(a_fault_zero, i_clk, i_rst_n, o_valid && (o_result.status == pbp_pkg::ST_BAD_CFG || o_result.status == pbp_pkg::ST_BAD_DEPTH), o_result.cam_x == 0 && o_result.cam_y == 0 && o_result.cam_z == 0, "fault result not zeroed")
    `ASSERT_IMPLIES(a_sat_bound, i_clk, i_rst_n, o_valid && o_result.status == pbp_pkg::ST_SAT, o_result.cam_x == 32'h7FFF_FFFF || o_result.cam_x == 32'h8000_0000 || o_result.cam_y == 32'h7FFF_FFFF || o_result.cam_y == 32'h8000_0000, "saturated result not at a bound")
    `ASSERT_IMPLIES(a_depth_nonzero, i_clk, i_rst_n, o_valid && (o_result.status == pbp_pkg::ST_OK || o_result.status == pbp_pkg::ST_SAT), o_result.cam_z != 0, "good result with zero depth")

endmodule

bind pixel_back_projection_top pbp_checker u_pbp_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for pixel_back_projection_top: random and directed targets against a predictor.
`timescale 1ns / 1ps
module tb;
    import pbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint CAM_MAX = (longint'(1) <<< 31) - 1;
    localparam longint CAM_MIN = -(longint'(1) <<< 31);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    class backproj_board;
        t_cfg    regs;
        t_result expected_q[$];
        int      errors;
        int      n_targets;
        int      n_checked;
        int      status_seen[4];

        function new();
            regs.focal_x       = RST_FOCAL_X;
            regs.focal_y       = RST_FOCAL_Y;
            regs.center_x      = RST_CENTER_X;
            regs.center_y      = RST_CENTER_Y;
            regs.default_depth = RST_DEFAULT_DEPTH;
            regs.image_width   = RST_IMAGE_SIZE;
            regs.image_height  = RST_IMAGE_SIZE;
            errors    = 0;
            n_targets = 0;
            n_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FOCAL_X:       regs.focal_x       = data[FOC_W-1:0];
                REG_FOCAL_Y:       regs.focal_y       = data[FOC_W-1:0];
                REG_CENTER_X:      regs.center_x      = data[PIX_W-1:0];
                REG_CENTER_Y:      regs.center_y      = data[PIX_W-1:0];
                REG_DEFAULT_DEPTH: regs.default_depth = data[DEP_W-1:0];
                REG_IMAGE_WIDTH:   regs.image_width   = data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  regs.image_height  = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit cfg_good();
            bit size_ok;
            size_ok = (regs.image_width == 0) == (regs.image_height == 0);
            return regs.focal_x != 0 && regs.focal_y != 0 && regs.default_depth != 0 && size_ok;
        endfunction

        // (pix - ctr) * z / f, truncated toward zero, clamped to 32 bits signed
        function longint axis_quot(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] ctr,
                                   logic [DEP_W-1:0] z, logic [FOC_W-1:0] f, inout bit sat);
            longint num;
            longint q;
            num = (longint'(pix) - longint'(ctr)) * longint'(z);
            q   = num / longint'(f);
            if (q > CAM_MAX) begin
                sat = 1'b1;
                return CAM_MAX;
            end
            if (q < CAM_MIN) begin
                sat = 1'b1;
                return CAM_MIN;
            end
            return q;
        endfunction

        function t_result back_project(t_target t);
            t_result          r;
            logic [DEP_W-1:0] z;
            bit               sat;
            longint           qx;
            longint           qy;
            r = '0;
            if (!cfg_good()) begin
                r.status = ST_BAD_CFG;
                return r;
            end
            z = t.depth_present ? t.target_depth : regs.default_depth;
            if (z == 0) begin
                r.status = ST_BAD_DEPTH;
                return r;
            end
            sat = 1'b0;
            qx = axis_quot(t.pixel_x, regs.center_x, z, regs.focal_x, sat);
            qy = axis_quot(t.pixel_y, regs.center_y, z, regs.focal_y, sat);
            r.cam_x  = CAM_W'(qx);
            r.cam_y  = CAM_W'(qy);
            r.cam_z  = z;
            r.status = sat ? ST_SAT : ST_OK;
            return r;
        endfunction

        function void note_target(t_target t);
            expected_q.push_back(back_project(t));
            n_targets++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("tb: mismatch: %s", msg);
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            exp = expected_q.pop_front();
            n_checked++;
            status_seen[exp.status]++;
            if (got.cam_x !== exp.cam_x)
                report($sformatf("result %0d cam_x got %0d want %0d",
                                 n_checked, got.cam_x, exp.cam_x));
            if (got.cam_y !== exp.cam_y)
                report($sformatf("result %0d cam_y got %0d want %0d",
                                 n_checked, got.cam_y, exp.cam_y));
            if (got.cam_z !== exp.cam_z)
                report($sformatf("result %0d cam_z got %0d want %0d",
                                 n_checked, got.cam_z, exp.cam_z));
            if (got.status !== exp.status)
                report($sformatf("result %0d status got %0d want %0d",
                                 n_checked, got.status, exp.status));
        endtask
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_target               i_target   = '0;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    backproj_board board;
    int            stall_cycles = 0;
    int            n_settings   = 1;

    always #1 i_clk = ~i_clk;

    pixel_back_projection_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_target   (i_target),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.set_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy) board.note_target(i_target);
            if (o_valid) board.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic t_target mk_target(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                          logic dp, logic [DEP_W-1:0] d);
        t_target t;
        t.pixel_x       = px;
        t.pixel_y       = py;
        t.depth_present = dp;
        t.target_depth  = d;
        return t;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] ctr);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 40) begin
            v = int'(ctr) + int'($urandom_range(0, 128)) - 64;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return PIX_W'(v);
        end
        return PIX_W'($urandom);
    endfunction

    function automatic logic [DEP_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < 12) return '1;
        if (r < 30) return DEP_W'($urandom_range(1, 4095));
        return DEP_W'($urandom);
    endfunction

    function automatic logic [FOC_W-1:0] pick_focal();
        int r;
        r = $urandom_range(0, 29);
        if (r == 0) return '0;
        if (r < 4) return FOC_W'($urandom_range(1, 64));
        return FOC_W'($urandom_range(200, 1048575));
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   r;
        c.focal_x  = pick_focal();
        c.focal_y  = pick_focal();
        c.center_x = PIX_W'($urandom);
        c.center_y = PIX_W'($urandom);
        r = $urandom_range(0, 19);
        c.default_depth = (r == 0) ? '0 : DEP_W'($urandom_range(1, 16777215));
        r = $urandom_range(0, 19);
        c.image_width  = SIZE_W'($urandom_range(1, 4095));
        c.image_height = SIZE_W'($urandom_range(1, 4095));
        if (r == 0) c.image_height = '0;
        else if (r == 1) c.image_width = '0;
        else if (r < 10) begin
            c.image_width  = '0;
            c.image_height = '0;
        end
        return c;
    endfunction

    function automatic t_target rand_target();
        t_target t;
        t.pixel_x       = pick_pixel(board.regs.center_x);
        t.pixel_y       = pick_pixel(board.regs.center_y);
        t.depth_present = 1'($urandom_range(0, 1));
        t.target_depth  = pick_depth();
        return t;
    endfunction

    function automatic int pick_gap(bit dense);
        int r;
        if (dense) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task send_target(input t_target t, input int gap);
        start    <= 1'b1;
        i_target <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task wait_drained();
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // upper bits beyond the register width carry junk; the block must drop them
    task cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                  input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk       = CFG_DATA_W'($urandom);
        junk       = junk << width;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= junk | val;
        @(posedge i_clk);
    endtask

    task load_config(input t_cfg c);
        start <= 1'b0;
        wait_drained();
        cfg_beat(REG_FOCAL_X, CFG_DATA_W'(c.focal_x), FOC_W);
        cfg_beat(REG_FOCAL_Y, CFG_DATA_W'(c.focal_y), FOC_W);
        cfg_beat(REG_CENTER_X, CFG_DATA_W'(c.center_x), PIX_W);
        cfg_beat(REG_CENTER_Y, CFG_DATA_W'(c.center_y), PIX_W);
        cfg_beat(REG_DEFAULT_DEPTH, CFG_DATA_W'(c.default_depth), DEP_W);
        cfg_beat(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width), SIZE_W);
        cfg_beat(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height), SIZE_W);
        cfg_beat(REG_UNUSED, CFG_DATA_W'($urandom), CFG_DATA_W);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        t_cfg c;
        t_cfg base;
        int   ph;
        int   k;
        int   n_items;
        board = new();
        base  = board.regs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: center, corners, zero and extreme depth
        send_target(mk_target(16'd5120, 16'd3840, 1'b0, 24'd0), 0);
        send_target(mk_target(16'd0, 16'd0, 1'b0, 24'd0), 1);
        send_target(mk_target(16'hFFFF, 16'hFFFF, 1'b1, 24'hFFFFFF), 0);
        send_target(mk_target(16'd100, 16'd200, 1'b1, 24'd0), 2);
        send_target(mk_target(16'hFFFF, 16'd0, 1'b1, 24'd1), 0);
        send_target(mk_target(16'd1, 16'hFFFE, 1'b1, 24'h800000), 0);

        // unit focal lengths: clamps in both directions
        c = base;
        c.focal_x = 20'd1;
        c.focal_y = 20'd1;
        c.center_x = 16'h8000;
        c.center_y = 16'h8000;
        c.default_depth = 24'hFFFFFF;
        load_config(c);
        send_target(mk_target(16'hFFFF, 16'd0, 1'b0, 24'd0), 0);
        send_target(mk_target(16'd0, 16'hFFFF, 1'b1, 24'hFFFFFF), 0);
        send_target(mk_target(16'h8000, 16'h8001, 1'b1, 24'd128), 0);
        send_target(mk_target(16'h8000, 16'h8000, 1'b1, 24'd0), 0);

        // invalid settings, each on its own
        c = base;
        c.focal_x = '0;
        load_config(c);
        send_target(mk_target(16'd5000, 16'd3000, 1'b1, 24'd0), 0);
        send_target(mk_target(16'hFFFF, 16'hFFFF, 1'b0, 24'd0), 0);
        c = base;
        c.focal_y = '0;
        load_config(c);
        send_target(mk_target(16'd7000, 16'd100, 1'b1, 24'd70000), 0);
        c = base;
        c.image_width = 12'd640;
        load_config(c);
        send_target(mk_target(16'd7000, 16'd100, 1'b1, 24'd70000), 0);
        c = base;
        c.image_height = 12'd480;
        load_config(c);
        send_target(mk_target(16'd7000, 16'd100, 1'b0, 24'd0), 0);
        c = base;
        c.default_depth = '0;
        c.image_width = 12'd640;
        c.image_height = 12'd480;
        load_config(c);
        send_target(mk_target(16'd7000, 16'd100, 1'b1, 24'd1000), 0);
        send_target(mk_target(16'd7000, 16'd100, 1'b0, 24'd0), 0);

        // widest focal length, far corner center: truncation of negatives toward zero
        c.focal_x = '1;
        c.focal_y = '1;
        c.center_x = '1;
        c.center_y = '1;
        c.default_depth = 24'd1;
        c.image_width = '1;
        c.image_height = '1;
        load_config(c);
        send_target(mk_target(16'd0, 16'd0, 1'b0, 24'd0), 0);
        send_target(mk_target(16'd0, 16'd1, 1'b1, 24'hFFFFFF), 0);
        send_target(mk_target(16'hFFFF, 16'hFFFF, 1'b1, 24'd5), 0);

        for (ph = 0; ph < 9; ph++) begin
            n_items = 150;
            if (ph == 0) begin
                c.focal_x = '1;
                c.focal_y = '1;
                c.center_x = '1;
                c.center_y = '1;
                c.default_depth = '1;
                c.image_width = '1;
                c.image_height = '1;
            end else if (ph == 1) begin
                c = '0;
                n_items = 10;
            end else begin
                c = rand_cfg();
            end
            load_config(c);
            for (k = 0; k < n_items; k++)
                send_target(rand_target(), pick_gap(ph % 3 == 2));
        end

        start <= 1'b0;
        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        $display("tb: %0d targets, %0d results checked, %0d register settings",
                 board.n_targets, board.n_checked, n_settings);
        $display("tb: outcomes ok %0d, bad config %0d, bad depth %0d, clamped %0d",
                 board.status_seen[ST_OK], board.status_seen[ST_BAD_CFG],
                 board.status_seen[ST_BAD_DEPTH], board.status_seen[ST_SAT]);
        if (board.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pbp_pkg.sv
rtl/pbp_front.sv
rtl/pbp_cell.sv
rtl/pbp_back.sv
rtl/pixel_back_projection_top.sv
rtl/pbp_checker.sv
tb/sv/tb.sv
